### design/mrialu_pkg.sv
// Shared types and operation codes for the midpoint-radius interval ALU.
package mrialu_pkg;

  localparam logic [2:0] ACT_ADD  = 3'd0;
  localparam logic [2:0] ACT_SUB  = 3'd1;
  localparam logic [2:0] ACT_MUL  = 3'd2;
  localparam logic [2:0] ACT_DIV  = 3'd3;
  localparam logic [2:0] ACT_SDIV = 3'd4;

  typedef struct packed {
    logic [2:0]         op;
    logic               fault;
    logic               bzero;
    logic               am_neg;
    logic               sgn_mid;
    logic               sgn_rgt;
    logic signed [32:0] sum_mid;
    logic signed [32:0] sum_rad;
    logic signed [63:0] pmm;
    logic signed [65:0] prad;
  } ctl_t;

endpackage

### design/mrialu_front.sv
// Input capture, products, sums and divider setup (three register stages).
module mrialu_front import mrialu_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int NW = 33 + FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_a_mid,
  input  logic signed [31:0] in_a_rad,
  input  logic signed [31:0] in_b_mid,
  input  logic signed [31:0] in_b_rad,
  output logic               f_valid,
  output ctl_t               f_ctl,
  output logic [32:0]        f_mid_d,
  output logic [NW-1:0]      f_mid_n,
  output logic [32:0]        f_rgt_d,
  output logic [NW-1:0]      f_rgt_n
);

  logic               v0_r, v1_r, v2_r;
  logic [2:0]         op0_r;
  logic signed [31:0] am_r, ar_r, bm_r, br_r;

  ctl_t               c1_r, c1_nxt;
  logic signed [63:0] p1_r, p2_r, p3_r;
  logic [32:0]        md1_r, mn1_r, rd1_r, rn1_r;

  ctl_t               c2_r, c2_nxt;
  logic [32:0]        md2_r, mn2_r, rd2_r, rn2_r;

  logic signed [32:0] left, nr;

  always_comb begin
    left = 33'(bm_r) - 33'(br_r);
    nr   = (op0_r == ACT_DIV) ? 33'(am_r) + 33'(ar_r) : 33'(am_r);
    c1_nxt = '0;
    c1_nxt.op      = op0_r;
    c1_nxt.fault   = left[32] | (left == '0);
    c1_nxt.bzero   = (bm_r == '0);
    c1_nxt.am_neg  = am_r[31];
    c1_nxt.sgn_mid = am_r[31] ^ bm_r[31];
    c1_nxt.sgn_rgt = nr[32];
    c1_nxt.sum_mid = (op0_r == ACT_SUB) ? 33'(am_r) - 33'(bm_r) : 33'(am_r) + 33'(bm_r);
    c1_nxt.sum_rad = 33'(ar_r) + 33'(br_r);
    c1_nxt.pmm     = am_r * bm_r;
    c1_nxt.prad    = '0;
  end

  always_comb begin
    c2_nxt      = c1_r;
    c2_nxt.prad = 66'(p1_r) + 66'(p2_r) + 66'(p3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0_r <= in_action;
      am_r  <= in_a_mid;
      ar_r  <= in_a_rad;
      bm_r  <= in_b_mid;
      br_r  <= in_b_rad;

      c1_r  <= c1_nxt;
      p1_r  <= am_r * br_r;
      p2_r  <= ar_r * bm_r;
      p3_r  <= ar_r * br_r;
      mn1_r <= am_r[31] ? -33'(am_r) : 33'(am_r);
      md1_r <= bm_r[31] ? -33'(bm_r) : 33'(bm_r);
      rn1_r <= nr[32] ? -nr : nr;
      rd1_r <= left;

      c2_r  <= c2_nxt;
      md2_r <= md1_r;
      mn2_r <= mn1_r;
      rd2_r <= rd1_r;
      rn2_r <= rn1_r;
    end
  end

  assign f_valid = v2_r;
  assign f_ctl   = c2_r;
  assign f_mid_d = md2_r;
  assign f_rgt_d = rd2_r;
  assign f_mid_n = NW'({mn2_r, {FRAC_BITS{1'b0}}});
  assign f_rgt_n = NW'({rn2_r, {FRAC_BITS{1'b0}}});

endmodule

### design/mrialu_div_step.sv
// One registered quotient bit of a pipelined restoring divider.
module mrialu_div_step #(
  parameter int NW = 49
) (
  input  logic          clk,
  input  logic          adv,
  input  logic [32:0]   rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [32:0]   d_i,
  output logic [32:0]   rem_o,
  output logic [NW-1:0] nq_o,
  output logic [32:0]   d_o
);

  logic [33:0] t, diff;
  logic        ge;

  always_comb begin
    t    = {rem_i, nq_i[NW-1]};
    diff = t - {1'b0, d_i};
    ge   = (t >= {1'b0, d_i});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_o <= ge ? diff[32:0] : t[32:0];
      nq_o  <= {nq_i[NW-2:0], ge};
      d_o   <= d_i;
    end
  end

endmodule

### design/mrialu_back.sv
// Quotient signs, result selection and saturation into the output register.
module mrialu_back import mrialu_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int NW = 33 + FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               b_valid,
  input  ctl_t               b_ctl,
  input  logic [NW-1:0]      b_qm,
  input  logic [NW-1:0]      b_qr,
  output logic               out_valid,
  output logic signed [31:0] out_res_mid,
  output logic signed [31:0] out_res_rad,
  output logic               out_divisor_fault,
  output logic               out_overflow
);

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  function automatic sat_t sat32(input logic signed [67:0] v);
    sat_t s;
    s.ovf = 1'b1;
    if (v > 68'sd2147483647)       s.val = 32'h7fffffff;
    else if (v < -68'sd2147483648) s.val = 32'h80000000;
    else begin
      s.val = v[31:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  function automatic logic signed [NW:0] c1_sgn(input logic neg, input logic [NW-1:0] q);
    logic signed [NW:0] w;
    w = $signed({1'b0, q});
    return neg ? -w : w;
  endfunction

  logic               v1_r, ov_r;
  ctl_t               c1_r;
  logic signed [NW:0] qm_r, qr_r;
  logic [31:0]        mid_r, rad_r;
  logic               flt_r, ovf_r;

  logic signed [NW+1:0] qd;
  sat_t                 sm, sr;
  logic [31:0]          mid_nxt, rad_nxt;
  logic                 flt_nxt, ovf_nxt;

  always_comb begin
    qd      = (NW+2)'(qr_r) - (NW+2)'(qm_r);
    sm      = '0;
    sr      = '0;
    mid_nxt = '0;
    rad_nxt = '0;
    flt_nxt = 1'b0;
    ovf_nxt = 1'b0;
    unique case (c1_r.op)
      ACT_ADD, ACT_SUB: begin
        sm = sat32(68'(c1_r.sum_mid));
        sr = sat32(68'(c1_r.sum_rad));
        mid_nxt = sm.val;
        rad_nxt = sr.val;
        ovf_nxt = sm.ovf | sr.ovf;
      end
      ACT_MUL: begin
        sm = sat32(68'(c1_r.pmm >>> FRAC_BITS));
        sr = sat32(68'(c1_r.prad >>> FRAC_BITS));
        mid_nxt = sm.val;
        rad_nxt = sr.val;
        ovf_nxt = sm.ovf | sr.ovf;
      end
      ACT_DIV, ACT_SDIV: begin
        sm = sat32(68'(qm_r));
        sr = sat32(68'(qd));
        if (c1_r.fault) begin
          flt_nxt = 1'b1;
        end else if (c1_r.bzero) begin
          mid_nxt = c1_r.am_neg ? 32'h80000000 : 32'h7fffffff;
          ovf_nxt = 1'b1;
        end else begin
          mid_nxt = sm.val;
          rad_nxt = sr.val;
          ovf_nxt = sm.ovf | sr.ovf;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      v1_r <= b_valid;
      ov_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r  <= b_ctl;
      qm_r  <= c1_sgn(b_ctl.sgn_mid, b_qm);
      qr_r  <= c1_sgn(b_ctl.sgn_rgt, b_qr);
      mid_r <= mid_nxt;
      rad_r <= rad_nxt;
      flt_r <= flt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid         = ov_r;
  assign out_res_mid       = mid_r;
  assign out_res_rad       = rad_r;
  assign out_divisor_fault = flt_r;
  assign out_overflow      = ovf_r;

endmodule

### design/midpoint_radius_interval_alu.sv
// Midpoint-radius interval ALU top level.
// Pipeline stages from accepted word to out_valid:
//   three front stages, 33 + FRAC_BITS divider stages (one per quotient bit), two back.
// Throughput: one word per cycle; the whole pipeline holds while out_stall is high
//   and a result is waiting.
// Reset: synchronous active-low rst_n clears all valid bits; data registers are not reset.
module midpoint_radius_interval_alu import mrialu_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_a_mid,
  input  logic signed [31:0] in_a_rad,
  input  logic signed [31:0] in_b_mid,
  input  logic signed [31:0] in_b_rad,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_res_mid,
  output logic signed [31:0] out_res_rad,
  output logic               out_divisor_fault,
  output logic               out_overflow
);

  localparam int NW = 33 + FRAC_BITS;

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic          vp_r  [0:NW];
  ctl_t          cp_r  [0:NW];
  logic [32:0]   mrem  [0:NW];
  logic [NW-1:0] mnq   [0:NW];
  logic [32:0]   md    [0:NW];
  logic [32:0]   rrem  [0:NW];
  logic [NW-1:0] rnq   [0:NW];
  logic [32:0]   rd    [0:NW];

  logic f_valid;
  ctl_t f_ctl;

  mrialu_front #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_a_mid  (in_a_mid),
    .in_a_rad  (in_a_rad),
    .in_b_mid  (in_b_mid),
    .in_b_rad  (in_b_rad),
    .f_valid   (f_valid),
    .f_ctl     (f_ctl),
    .f_mid_d   (md[0]),
    .f_mid_n   (mnq[0]),
    .f_rgt_d   (rd[0]),
    .f_rgt_n   (rnq[0])
  );

  always_comb begin
    vp_r[0] = f_valid;
    cp_r[0] = f_ctl;
  end

  assign mrem[0] = '0;
  assign rrem[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_div
    mrialu_div_step #(.NW(NW)) u_mid (
      .clk   (clk),
      .adv   (adv),
      .rem_i (mrem[i]),
      .nq_i  (mnq[i]),
      .d_i   (md[i]),
      .rem_o (mrem[i+1]),
      .nq_o  (mnq[i+1]),
      .d_o   (md[i+1])
    );

    mrialu_div_step #(.NW(NW)) u_rgt (
      .clk   (clk),
      .adv   (adv),
      .rem_i (rrem[i]),
      .nq_i  (rnq[i]),
      .d_i   (rd[i]),
      .rem_o (rrem[i+1]),
      .nq_o  (rnq[i+1]),
      .d_o   (rd[i+1])
    );

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vp_r[i+1] <= 1'b0;
      end else if (adv) begin
        vp_r[i+1] <= vp_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cp_r[i+1] <= cp_r[i];
      end
    end
  end

  mrialu_back #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .adv               (adv),
    .b_valid           (vp_r[NW]),
    .b_ctl             (cp_r[NW]),
    .b_qm              (mnq[NW]),
    .b_qr              (rnq[NW]),
    .out_valid         (out_valid),
    .out_res_mid       (out_res_mid),
    .out_res_rad       (out_res_rad),
    .out_divisor_fault (out_divisor_fault),
    .out_overflow      (out_overflow)
  );

endmodule

### tb/tb.sv
// Testbench for midpoint_radius_interval_alu: directed and random words checked against a predictor.
`timescale 1ns / 100ps
module tb import mrialu_pkg::*; ();

  localparam int FB = 16;
  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;

  typedef struct {
    logic signed [31:0] mid;
    logic signed [31:0] rad;
    logic               fault;
    logic               ovf;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_action = '0;
  logic signed [31:0] in_a_mid = '0, in_a_rad = '0, in_b_mid = '0, in_b_rad = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_res_mid, out_res_rad;
  logic out_divisor_fault, out_overflow;

  alu_res_t expected_q[$];
  int errors = 0;
  bit calm = 0;

  midpoint_radius_interval_alu dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint sat32(longint v, ref logic ovf);
    if (v > QMAX) begin ovf = 1; return QMAX; end
    if (v < QMIN) begin ovf = 1; return QMIN; end
    return v;
  endfunction

  function automatic alu_res_t interval_calc(logic [2:0] act, logic signed [31:0] am,
                                             logic signed [31:0] ar, logic signed [31:0] bm,
                                             logic signed [31:0] br);
    alu_res_t r;
    logic ovf;
    logic signed [127:0] acc, qr, qm, nr, lft;
    ovf = 0;
    r.mid = 0; r.rad = 0; r.fault = 0;
    case (act)
      ACT_ADD: begin
        r.mid = 32'(sat32(longint'(am) + bm, ovf));
        r.rad = 32'(sat32(longint'(ar) + br, ovf));
      end
      ACT_SUB: begin
        r.mid = 32'(sat32(longint'(am) - bm, ovf));
        r.rad = 32'(sat32(longint'(ar) + br, ovf));
      end
      ACT_MUL: begin
        acc = (128'(am) * bm) >>> FB;
        r.mid = 32'(sat32(acc > QMAX ? QMAX + 1 : acc < QMIN ? QMIN - 1 : longint'(acc), ovf));
        acc = (128'(am) * br + 128'(ar) * bm + 128'(ar) * br) >>> FB;
        r.rad = 32'(sat32(acc > QMAX ? QMAX + 1 : acc < QMIN ? QMIN - 1 : longint'(acc), ovf));
      end
      ACT_DIV, ACT_SDIV: begin
        lft = 128'(bm) - br;
        if (lft <= 0) r.fault = 1;
        else begin
          nr = (act == ACT_DIV) ? 128'(am) + ar : 128'(am);
          qr = (nr <<< FB) / lft;
          if (bm == 0) begin
            ovf = 1;
            r.mid = (am >= 0) ? 32'h7fffffff : 32'h80000000;
          end else begin
            qm = (128'(am) <<< FB) / bm;
            r.mid = 32'(sat32(qm > QMAX ? QMAX + 1 : qm < QMIN ? QMIN - 1 : longint'(qm), ovf));
            acc = qr - qm;
            r.rad = 32'(sat32(acc > QMAX ? QMAX + 1 : acc < QMIN ? QMIN - 1 : longint'(acc),
                              ovf));
          end
        end
      end
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  task automatic send_word(logic [2:0] act, logic signed [31:0] am, logic signed [31:0] ar,
                           logic signed [31:0] bm, logic signed [31:0] br);
    while (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act; in_a_mid <= am; in_a_rad <= ar; in_b_mid <= bm; in_b_rad <= br;
    expected_q.push_back(interval_calc(act, am, ar, bm, br));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          alu_res_t e;
          e = expected_q.pop_front();
          if (e.mid !== out_res_mid) begin
            $error("res_mid exp %h got %h", e.mid, out_res_mid); errors++;
          end
          if (e.rad !== out_res_rad) begin
            $error("res_rad exp %h got %h", e.rad, out_res_rad); errors++;
          end
          if (e.fault !== out_divisor_fault) begin
            $error("divisor_fault exp %b got %b", e.fault, out_divisor_fault); errors++;
          end
          if (e.ovf !== out_overflow) begin
            $error("overflow exp %b got %b", e.ovf, out_overflow); errors++;
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 21);
    end
  end

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(8'hff)) - 128;
      2: return $signed($urandom_range(32'h3ffff)) - 32'sh20000;
      3: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return $signed($urandom_range(32'h7ffffff)) - 32'sh4000000;
    endcase
  endfunction

  task automatic test_extremes();
    logic signed [31:0] ex[4] = '{32'h7fffffff, 32'h80000000, 0, 32'h00010000};
    for (int a = 0; a < 5; a++) begin
      send_word(a[2:0], ex[0], ex[0], ex[0], ex[0]);
      send_word(a[2:0], ex[1], ex[1], ex[1], ex[1]);
      send_word(a[2:0], ex[3], ex[2], ex[3], ex[2]);
    end
  endtask

  task automatic test_special_cases();
    send_word(ACT_DIV, 32'h00010000, 0, 32'h00010000, 32'h00010000);
    send_word(ACT_SDIV, 32'h00010000, 0, 32'h00010000, 32'h00020000);
    send_word(ACT_DIV, 32'h00050000, 1, 0, -32'sd5);
    send_word(ACT_SDIV, -32'sd7, 1, 0, -32'sd5);
    send_word(ACT_DIV, 0, 0, 0, 32'h80000000);
    send_word(3'd5, 1, 2, 3, 4);
    send_word(3'd6, -1, -1, -1, -1);
    send_word(3'd7, 32'h7fffffff, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 2 && i < n / 2 + 60);
      send_word($urandom_range(9) == 0 ? 3'($urandom_range(7)) : 3'($urandom_range(4)),
                rnd_val(), rnd_val(), rnd_val(), rnd_val());
      if (i == n / 3) begin
        go_idle();
        while (expected_q.size() != 0) @(posedge clk);
      end
    end
    calm = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_special_cases();
    test_random(400);
    go_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### files.f
design/mrialu_pkg.sv
design/mrialu_front.sv
design/mrialu_div_step.sv
design/mrialu_back.sv
design/midpoint_radius_interval_alu.sv
tb/tb.sv
